// ----- design/tbgr_pkg.sv -----
// shared types, constants and functions for the text and block graphics raster
// no dependencies
`timescale 1ns / 1ps

package tbgr_pkg;

	// raster geometry in cells
	localparam int CELLS_PER_LINE = 64;
	localparam int CELL_ROWS      = 32;

	// cell size in pixels
	localparam int CELL_W = 6;
	localparam int CELL_H = 8;

	localparam int RASTER_W = CELLS_PER_LINE * CELL_W;
	localparam int RASTER_H = CELL_ROWS * CELL_H;

	// payload widths
	localparam int OPCODE_W  = 2;
	localparam int ADDR_W    = 11;
	localparam int DATA_W    = 8;
	localparam int INDEX_W   = 3;
	localparam int LEVEL_W   = 8;
	localparam int COLUMN_W  = 9;
	localparam int ROW_W     = 8;

	// store geometry
	localparam int CELL_DEPTH  = 2048;
	localparam int GLYPH_DEPTH = 1024;
	localparam int CELL_AW     = $clog2(CELL_DEPTH);
	localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);

	// internal scan counter widths
	localparam int SCOL_W = $clog2(RASTER_W + 1);
	localparam int SROW_W = $clog2(RASTER_H + 1);
	localparam int CX_W   = (CELLS_PER_LINE > 1) ? $clog2(CELLS_PER_LINE) : 1;
	localparam int CY_W   = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;
	localparam int PX_W   = $clog2(CELL_W);
	localparam int PY_W   = $clog2(CELL_H);

	// cell byte fields
	localparam int BLOCK_FLAG_BIT = 7;
	localparam int GREY_LSB       = 4;
	localparam int CODE_W         = 7;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CELL_WR  = 2'd0,
		OP_GLYPH_WR = 2'd1,
		OP_TICK     = 2'd2
	} opcode_t;

	// palette expansion of a 3-bit index to 8 bits
	function automatic logic [LEVEL_W-1:0] expand_level(input logic [INDEX_W-1:0] i);
		expand_level = {i, i, i[2:1]};
	endfunction

endpackage

// ----- design/tbgr_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// read returns the old contents when both ports hit the same entry; no dependencies
`timescale 1ns / 1ps

module tbgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and read-first registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/text_and_block_graphics_raster_top.sv -----
// text and block graphics raster generator, top level
// depends on tbgr_pkg and tbgr_ram
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, opcode, address,      | into block
//          | write_data                                |
//  out     | out_valid, out_ready, grey_index,         | out of block
//          | grey_level, pixel_column, pixel_row,      |
//          | line_end, frame_end                       |
//
// one transaction per cycle sustained while out_ready stays high.
// the cell store is read in the tick cycle, the glyph store from the registered cell byte
// in stage 1, then the pixel is formed into the output register.
// a glyph write waits while a tick holds stalled ahead of its glyph read.
// reset clears the scan position and pipeline valids; the stores power up unknown.
// when out_ready is low the pipeline fills its empty stages before in_ready drops.
`timescale 1ns / 1ps

module text_and_block_graphics_raster_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tbgr_pkg::OPCODE_W-1:0]  opcode,
	input  logic [tbgr_pkg::ADDR_W-1:0]    address,
	input  logic [tbgr_pkg::DATA_W-1:0]    write_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tbgr_pkg::INDEX_W-1:0]   grey_index,
	output logic [tbgr_pkg::LEVEL_W-1:0]   grey_level,
	output logic [tbgr_pkg::COLUMN_W-1:0]  pixel_column,
	output logic [tbgr_pkg::ROW_W-1:0]     pixel_row,
	output logic                           line_end,
	output logic                           frame_end
);

	import tbgr_pkg::*;

	// scan position
	logic [SCOL_W-1:0] col_q, col_d;
	logic [SROW_W-1:0] row_q, row_d;
	logic [CX_W-1:0]   cx_q, cx_d;
	logic [CY_W-1:0]   cy_q, cy_d;
	logic [PX_W-1:0]   px_q, px_d;
	logic [PY_W-1:0]   py_q, py_d;

	// pipeline control
	logic v_s1, v_s2, out_valid_q;
	logic en_s1, en_s2, en_out;
	logic accept, tick_acc, cell_wr, glyph_wr;
	logic glyph_block;
	logic le_now, fe_now;

	// stage 1 side data (cell byte comes from the cell ram)
	logic [PX_W-1:0]     px_s1;
	logic [PY_W-1:0]     py_s1;
	logic [SCOL_W-1:0]   col_s1;
	logic [SROW_W-1:0]   row_s1;
	logic                le_s1, fe_s1;
	logic [DATA_W-1:0]   cell_rd;

	// stage 2 side data (glyph row comes from the glyph ram)
	logic [PX_W-1:0]     px_s2;
	logic                is_char_s2;
	logic [INDEX_W-1:0]  block_idx_s2;
	logic [SCOL_W-1:0]   col_s2;
	logic [SROW_W-1:0]   row_s2;
	logic                le_s2, fe_s2;
	logic [DATA_W-1:0]   glyph_rd;

	// stage 1 combinational
	logic [GLYPH_AW-1:0] glyph_rd_addr;
	logic                block_lit;
	logic [INDEX_W-1:0]  block_idx;
	logic                right_half;

	// stage 2 combinational
	logic [INDEX_W-1:0]  idx_s2;

	// output register
	logic [INDEX_W-1:0]  idx_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [SCOL_W-1:0]   col_q_out;
	logic [SROW_W-1:0]   row_q_out;
	logic                le_q, fe_q;

	logic [CELL_AW-1:0]  cell_rd_addr;

	// stall chain: a stage moves when it is empty or the next one moves
	assign en_out = !out_valid_q || out_ready;
	assign en_s2  = !v_s2 || en_out;
	assign en_s1  = !v_s1 || en_s2;

	// a glyph write must not overtake a tick still waiting for its glyph read
	assign glyph_block = (opcode == OP_GLYPH_WR) && v_s1 && !en_s2;
	assign in_ready    = en_s1 && !glyph_block;

	assign accept   = in_valid && in_ready;
	assign tick_acc = accept && (opcode == OP_TICK);
	assign cell_wr  = accept && (opcode == OP_CELL_WR);
	assign glyph_wr = accept && (opcode == OP_GLYPH_WR);

	// end of line and frame at the current scan position
	assign le_now = (col_q == SCOL_W'(RASTER_W - 1));
	assign fe_now = le_now && (row_q == SROW_W'(RASTER_H - 1));

	// next scan position
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		cx_d  = cx_q;
		cy_d  = cy_q;
		px_d  = px_q;
		py_d  = py_q;
		if (le_now) begin
			col_d = '0;
			cx_d  = '0;
			px_d  = '0;
			if (fe_now) begin
				row_d = '0;
				cy_d  = '0;
				py_d  = '0;
			end else begin
				row_d = row_q + 1'b1;
				if (py_q == PY_W'(CELL_H - 1)) begin
					py_d = '0;
					cy_d = cy_q + 1'b1;
				end else begin
					py_d = py_q + 1'b1;
				end
			end
		end else begin
			col_d = col_q + 1'b1;
			if (px_q == PX_W'(CELL_W - 1)) begin
				px_d = '0;
				cx_d = cx_q + 1'b1;
			end else begin
				px_d = px_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cx_q  <= '0;
			cy_q  <= '0;
			px_q  <= '0;
			py_q  <= '0;
		end else if (tick_acc) begin
			col_q <= col_d;
			row_q <= row_d;
			cx_q  <= cx_d;
			cy_q  <= cy_d;
			px_q  <= px_d;
			py_q  <= py_d;
		end
	end

	// cell store, read at the tick
	assign cell_rd_addr = CELL_AW'(cy_q * CELLS_PER_LINE + cx_q);

	tbgr_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CELL_DEPTH)
	) u_cell_ram (
		.clk    (clk),
		.wr_en  (cell_wr),
		.wr_addr(address[CELL_AW-1:0]),
		.wr_data(write_data),
		.rd_en  (en_s1),
		.rd_addr(cell_rd_addr),
		.rd_data(cell_rd)
	);

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= tick_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1  <= px_q;
			py_s1  <= py_q;
			col_s1 <= col_q;
			row_s1 <= row_q;
			le_s1  <= le_now;
			fe_s1  <= fe_now;
		end
	end

	// stage 1: glyph address and block pixel
	assign glyph_rd_addr = GLYPH_AW'({cell_rd[CODE_W-1:0], py_s1});
	assign right_half    = (px_s1 >= PX_W'(CELL_W / 2));
	assign block_lit     = cell_rd[{py_s1[PY_W-1], right_half}];
	assign block_idx     = block_lit ? cell_rd[GREY_LSB +: INDEX_W] : '0;

	tbgr_ram #(
		.WIDTH(DATA_W),
		.DEPTH(GLYPH_DEPTH)
	) u_glyph_ram (
		.clk    (clk),
		.wr_en  (glyph_wr),
		.wr_addr(address[GLYPH_AW-1:0]),
		.wr_data(write_data),
		.rd_en  (en_s2),
		.rd_addr(glyph_rd_addr),
		.rd_data(glyph_rd)
	);

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			px_s2        <= px_s1;
			is_char_s2   <= !cell_rd[BLOCK_FLAG_BIT];
			block_idx_s2 <= block_idx;
			col_s2       <= col_s1;
			row_s2       <= row_s1;
			le_s2        <= le_s1;
			fe_s2        <= fe_s1;
		end
	end

	// stage 2: glyph pixel, leftmost pixel from the top used bit
	always_comb begin
		if (is_char_s2) begin
			idx_s2 = glyph_rd[PX_W'(CELL_W - 1) - px_s2] ? INDEX_W'(7) : '0;
		end else begin
			idx_s2 = block_idx_s2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			idx_q     <= idx_s2;
			level_q   <= expand_level(idx_s2);
			col_q_out <= col_s2;
			row_q_out <= row_s2;
			le_q      <= le_s2;
			fe_q      <= fe_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign grey_index   = idx_q;
	assign grey_level   = level_q;
	assign pixel_column = COLUMN_W'(col_q_out);
	assign pixel_row    = ROW_W'(row_q_out);
	assign line_end     = le_q;
	assign frame_end    = fe_q;

`ifndef NO_ASSERTIONS
	// no glyph write slips ahead of a stalled tick's glyph read
	a_glyph_order: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en_s2) |-> !glyph_wr)
		else $error("glyph write accepted ahead of pending glyph read");

	// scan position stays inside the raster
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < SCOL_W'(RASTER_W)) && (row_q < SROW_W'(RASTER_H)))
		else $error("scan position outside raster");

	// frame end only on a line end
	a_frame_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!fe_q || le_q))
		else $error("frame end without line end");

	// line end sits on the last column
	a_line_col: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && le_q) |-> (col_q_out == SCOL_W'(RASTER_W - 1)))
		else $error("line end away from last column");

	// a tick at frame end sends the scan back to the origin
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && fe_now) |=> (col_q == '0) && (row_q == '0))
		else $error("scan did not wrap at frame end");
`endif

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the text and block graphics raster generator
// drives store writes and pixel ticks, predicts every pixel and checks the output channel
// depends on tbgr_pkg and text_and_block_graphics_raster_top
`timescale 1ns / 1ps

module testbench;
	import tbgr_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [ADDR_W-1:0]   addr;
		logic [DATA_W-1:0]   data;
	} stim_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  grey_idx;
		logic [LEVEL_W-1:0]  level;
		logic [COLUMN_W-1:0] column;
		logic [ROW_W-1:0]    row;
		logic                line_last;
		logic                frame_last;
	} pixel_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode = '0;
	logic [ADDR_W-1:0]   address = '0;
	logic [DATA_W-1:0]   write_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [INDEX_W-1:0]  grey_index;
	logic [LEVEL_W-1:0]  grey_level;
	logic [COLUMN_W-1:0] pixel_column;
	logic [ROW_W-1:0]    pixel_row;
	logic                line_end;
	logic                frame_end;

	text_and_block_graphics_raster_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.address      (address),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.grey_index   (grey_index),
		.grey_level   (grey_level),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.line_end     (line_end),
		.frame_end    (frame_end)
	);

	// transactions waiting to be driven, and pixels waiting to come out
	stim_t  pending_q[$];
	pixel_t pixel_q[$];
	stim_t  current_item;
	int     tx_idle_pct = 0;
	int     rx_idle_pct = 0;
	int     error_count = 0;

	// predictor state
	logic [DATA_W-1:0] video_mem [CELL_DEPTH];
	logic [DATA_W-1:0] font_mem [GLYPH_DEPTH];
	int                beam_col = 0;
	int                beam_row = 0;

	// stimulus shadow: what has been written and where the scan will be
	logic [DATA_W-1:0] plan_cell [CELL_DEPTH];
	bit                plan_cell_set [CELL_DEPTH];
	bit                plan_glyph_set [GLYPH_DEPTH];
	int                plan_col = 0;
	int                plan_row = 0;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// apply one accepted transaction to the predictor, queue the pixel a tick yields
	task automatic predict_pixel(input stim_t it);
		int           cx, cy, px, py, sel;
		logic [DATA_W-1:0] cell_byte, pattern;
		logic [INDEX_W-1:0] idx;
		pixel_t       p;
		case (it.op)
			OP_CELL_WR: video_mem[it.addr] = it.data;
			OP_GLYPH_WR: font_mem[it.addr[GLYPH_AW-1:0]] = it.data;
			OP_TICK: begin
				cx = beam_col / CELL_W;
				px = beam_col % CELL_W;
				cy = beam_row / CELL_H;
				py = beam_row % CELL_H;
				cell_byte = video_mem[(cy * CELLS_PER_LINE + cx) % CELL_DEPTH];
				if (cell_byte[7]) begin
					// block graphics: quadrant bit picks lit or black, lit uses cell grey
					sel = ((py >= CELL_H / 2) ? 2 : 0) + ((px >= CELL_W / 2) ? 1 : 0);
					idx = cell_byte[sel] ? cell_byte[6:4] : '0;
				end else begin
					pattern = font_mem[(int'(cell_byte[6:0]) * CELL_H + py) % GLYPH_DEPTH];
					idx = pattern[5 - px] ? 3'd7 : 3'd0;
				end
				p.grey_idx   = idx;
				p.level      = {idx, 5'b0} | {3'b0, idx, 2'b0} | {5'b0, idx >> 1};
				p.column     = COLUMN_W'(beam_col);
				p.row        = ROW_W'(beam_row);
				p.line_last  = (beam_col == RASTER_W - 1);
				p.frame_last = p.line_last && (beam_row == RASTER_H - 1);
				pixel_q.push_back(p);
				// scan order, wrapping to the top left after the last pixel of the frame
				if (p.line_last) begin
					beam_col = 0;
					beam_row = p.frame_last ? 0 : beam_row + 1;
				end else begin
					beam_col++;
				end
			end
			default: ;
		endcase
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_pixel(current_item);
			if (!in_valid || in_ready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					current_item = pending_q.pop_front();
					in_valid   <= 1'b1;
					opcode     <= current_item.op;
					address    <= current_item.addr;
					write_data <= current_item.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{grey_index, grey_level, pixel_column, pixel_row, line_end, frame_end};
				if (pixel_q.size() == 0) begin
					report_error($sformatf("unexpected pixel col %0d row %0d",
						pixel_column, pixel_row));
				end else begin
					want = pixel_q.pop_front();
					if (got !== want)
						report_error($sformatf({"pixel mismatch: expected idx %0d lvl %0d ",
							"col %0d row %0d le %0b fe %0b, got idx %0d lvl %0d col %0d ",
							"row %0d le %0b fe %0b"},
							want.grey_idx, want.level, want.column, want.row,
							want.line_last, want.frame_last, got.grey_idx, got.level,
							got.column, got.row, got.line_last, got.frame_last));
				end
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog: ends the run when nothing moves for too long
	initial begin
		int stuck_cycles;
		stuck_cycles = 0;
		@(posedge arst_n);
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	// append a transaction and track what the stores and scan will hold
	task automatic queue_item(input logic [OPCODE_W-1:0] op, input int addr, input int data);
		stim_t it;
		it.op   = op;
		it.addr = ADDR_W'(addr);
		it.data = DATA_W'(data);
		pending_q.push_back(it);
		case (op)
			OP_CELL_WR: begin
				plan_cell[it.addr]     = it.data;
				plan_cell_set[it.addr] = 1'b1;
			end
			OP_GLYPH_WR: plan_glyph_set[it.addr[GLYPH_AW-1:0]] = 1'b1;
			OP_TICK: begin
				if (plan_col == RASTER_W - 1) begin
					plan_col = 0;
					plan_row = (plan_row == RASTER_H - 1) ? 0 : plan_row + 1;
				end else begin
					plan_col++;
				end
			end
			default: ;
		endcase
	endtask

	// a tick, preceded by writes to any store entry it would read unwritten
	task automatic queue_tick();
		int cell_addr, glyph_addr;
		cell_addr = ((plan_row / CELL_H) * CELLS_PER_LINE + plan_col / CELL_W) % CELL_DEPTH;
		if (!plan_cell_set[cell_addr])
			queue_item(OP_CELL_WR, cell_addr, $urandom_range(255));
		if (!plan_cell[cell_addr][7]) begin
			glyph_addr = int'(plan_cell[cell_addr][6:0]) * CELL_H + plan_row % CELL_H;
			// glyph address may carry the extra top bit, which wraps
			if (!plan_glyph_set[glyph_addr])
				queue_item(OP_GLYPH_WR, glyph_addr + $urandom_range(1) * GLYPH_DEPTH,
					$urandom_range(255));
		end
		queue_item(OP_TICK, $urandom_range(2047), $urandom_range(255));
	endtask

	// cell write somewhere on the cell row being scanned
	task automatic queue_row_cell_write();
		queue_item(OP_CELL_WR,
			((plan_row / CELL_H) * CELLS_PER_LINE + $urandom_range(CELLS_PER_LINE - 1))
			% CELL_DEPTH, $urandom_range(255));
	endtask

	// random traffic: mostly tick bursts, with writes aimed at the visible row
	task automatic queue_traffic(input int count);
		int done, r, burst, a;
		done = 0;
		while (done < count) begin
			r = $urandom_range(99);
			if (r < 55) begin
				burst = $urandom_range(24, 1);
				repeat (burst) queue_tick();
				done += burst;
			end else if (r < 75) begin
				if ($urandom_range(1))
					queue_row_cell_write();
				else
					queue_item(OP_CELL_WR, $urandom_range(2047), $urandom_range(255));
				done++;
			end else if (r < 92) begin
				a = ((plan_row / CELL_H) * CELLS_PER_LINE + $urandom_range(CELLS_PER_LINE - 1))
					% CELL_DEPTH;
				if (plan_cell_set[a] && !plan_cell[a][7] && $urandom_range(1))
					queue_item(OP_GLYPH_WR, int'(plan_cell[a][6:0]) * CELL_H +
						$urandom_range(CELL_H - 1) + $urandom_range(1) * GLYPH_DEPTH,
						$urandom_range(255));
				else
					queue_item(OP_GLYPH_WR, $urandom_range(2047), $urandom_range(255));
				done++;
			end else begin
				// unused opcode, must be dropped without a pixel
				queue_item(OP_RESERVED, $urandom_range(2047), $urandom_range(255));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || in_valid || pixel_q.size() != 0)
			@(posedge clk);
	endtask

	// stimulus sequence and verdict
	initial begin
		tx_idle_pct = 6;
		rx_idle_pct = 51;

		// directed: block cell at full grey, character cells with lowest and highest
		// codes, glyph write through a wrapping address, last cell, unused opcode
		queue_item(OP_CELL_WR, 0, 'hF9);
		queue_item(OP_CELL_WR, 1, 'h00);
		queue_item(OP_CELL_WR, 2, 'h7F);
		queue_item(OP_GLYPH_WR, 'h400, 'hE5);
		queue_item(OP_GLYPH_WR, 127 * CELL_H, 'h3F);
		queue_item(OP_CELL_WR, CELL_DEPTH - 1, 'h80);
		queue_item(OP_RESERVED, 'h7FF, 'hFF);
		repeat (18) queue_tick();
		queue_traffic(600);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// sender holds off until every pixel has come out
		wait_drained();
		@(negedge clk);
		tx_idle_pct = 51;
		rx_idle_pct = 6;
		queue_traffic(600);

		wait_drained();
		@(negedge clk);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_traffic(500);

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
